// ===== rtl/pixel_compositor_core_defines.svh =====
// Assertion macros shared by the pixel compositor RTL.
`ifndef PIXEL_COMPOSITOR_CORE_DEFINES_SVH
`define PIXEL_COMPOSITOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PXC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pixel compositor assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define PXC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pixel compositor assertion failed");

`endif

// ===== rtl/pxc_pkg.sv =====
// Package with types, codes and constants of the pixel compositor.
`timescale 1ns / 1ps

package pxc_pkg;

  localparam int NUM_CH = 4;
  localparam int CH_W = 8;
  localparam int PIX_W = NUM_CH * CH_W;
  localparam int WGT_W = 2 * CH_W;
  localparam int PROD_W = 24;
  localparam int REM_W = 18;

  localparam logic [2:0] MODE_COPY = 3'd0;
  localparam logic [2:0] MODE_KEY = 3'd1;
  localparam logic [2:0] MODE_TEST = 3'd2;
  localparam logic [2:0] MODE_PIXBLEND = 3'd3;
  localparam logic [2:0] MODE_CONSTBLEND = 3'd4;

  localparam logic [1:0] REG_BLEND_MODE = 2'd0;
  localparam logic [1:0] REG_KEY_COLOR = 2'd1;
  localparam logic [1:0] REG_ALPHA_LEVEL = 2'd2;

  localparam logic [2:0] BLEND_MODE_RESET = MODE_COPY;
  localparam logic [PIX_W-1:0] KEY_COLOR_RESET = 32'd0;
  localparam logic [CH_W-1:0] ALPHA_LEVEL_RESET = 8'd255;

  // Full-scale weight: 255 * 255.
  localparam logic [WGT_W-1:0] DEN = 16'd65025;
  localparam logic [REM_W-1:0] DEN_X1 = 18'd65025;
  localparam logic [REM_W-1:0] DEN_X2 = 18'd130050;
  localparam logic [REM_W-1:0] DEN_X3 = 18'd195075;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [NUM_CH-1:0][PROD_W-1:0] prod_t;

  typedef struct packed {
    logic blend;
    logic we;
  } ctl_t;

endpackage

// ===== rtl/pxc_front.sv =====
// First stage: mode decode, write enable and blend weight.
`timescale 1ns / 1ps

module pxc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pxc_pkg::pixel_t               src_pixel,
  input  pxc_pkg::pixel_t               dst_pixel,
  input  logic [2:0]                    blend_mode,
  input  pxc_pkg::pixel_t               key_color,
  input  logic [pxc_pkg::CH_W-1:0]      alpha_level,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pxc_pkg::pixel_t               src_q,
  output pxc_pkg::pixel_t               dst_q,
  output logic [pxc_pkg::WGT_W-1:0]     wgt_q,
  output pxc_pkg::ctl_t                 ctl_q
);

  logic [pxc_pkg::CH_W-1:0]  a_src;
  logic [pxc_pkg::WGT_W-1:0] wgt;
  pxc_pkg::ctl_t             ctl;

  assign a_src = src_pixel[pxc_pkg::PIX_W-1 -: pxc_pkg::CH_W];
  assign in_ready = !out_valid || out_ready;

  always_comb begin
    wgt = '0;
    ctl.blend = 1'b0;
    ctl.we = 1'b1;
    unique case (blend_mode)
      pxc_pkg::MODE_KEY: begin
        ctl.we = (src_pixel != key_color);
      end
      pxc_pkg::MODE_TEST: begin
        ctl.we = (a_src > alpha_level);
      end
      pxc_pkg::MODE_PIXBLEND: begin
        ctl.blend = 1'b1;
        wgt = pxc_pkg::WGT_W'(a_src) * pxc_pkg::WGT_W'(alpha_level);
      end
      pxc_pkg::MODE_CONSTBLEND: begin
        // The level is scaled by 255 so both blends share one divisor.
        ctl.blend = 1'b1;
        wgt = {alpha_level, {pxc_pkg::CH_W{1'b0}}} - {{pxc_pkg::CH_W{1'b0}}, alpha_level};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      src_q <= src_pixel;
      dst_q <= dst_pixel;
      wgt_q <= wgt;
      ctl_q <= ctl;
    end
  end

endmodule

// ===== rtl/pxc_mix.sv =====
// Second stage: weighted sum of source and destination for each channel.
`timescale 1ns / 1ps

module pxc_mix (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pxc_pkg::pixel_t               src_pixel,
  input  pxc_pkg::pixel_t               dst_pixel,
  input  logic [pxc_pkg::WGT_W-1:0]     wgt,
  input  pxc_pkg::ctl_t                 ctl,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pxc_pkg::pixel_t               src_q,
  output pxc_pkg::prod_t                prod_q,
  output pxc_pkg::ctl_t                 ctl_q
);

  logic [pxc_pkg::WGT_W-1:0]  wgt_inv;
  logic [pxc_pkg::PROD_W-1:0] wgt_x;
  logic [pxc_pkg::PROD_W-1:0] wgt_inv_x;
  pxc_pkg::prod_t             prod;

  assign wgt_inv = pxc_pkg::DEN - wgt;
  assign wgt_x = pxc_pkg::PROD_W'(wgt);
  assign wgt_inv_x = pxc_pkg::PROD_W'(wgt_inv);
  assign in_ready = !out_valid || out_ready;

  always_comb begin
    for (int ch = 0; ch < pxc_pkg::NUM_CH; ch++) begin
      prod[ch] = pxc_pkg::PROD_W'(dst_pixel[ch*pxc_pkg::CH_W +: pxc_pkg::CH_W]) * wgt_inv_x
               + pxc_pkg::PROD_W'(src_pixel[ch*pxc_pkg::CH_W +: pxc_pkg::CH_W]) * wgt_x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      src_q <= src_pixel;
      prod_q <= prod;
      ctl_q <= ctl;
    end
  end

endmodule

// ===== rtl/pxc_div.sv =====
// Third and fourth stages: division by 65025 and the output register.
`timescale 1ns / 1ps

module pxc_div (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pxc_pkg::pixel_t       src_pixel,
  input  pxc_pkg::prod_t        prod,
  input  pxc_pkg::ctl_t         ctl,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pxc_pkg::pixel_t       out_pixel,
  output logic                  write_enable
);

  logic                                          est_valid;
  logic                                          est_ready;
  logic [pxc_pkg::NUM_CH-1:0][pxc_pkg::CH_W-1:0] quo;
  logic [pxc_pkg::NUM_CH-1:0][pxc_pkg::REM_W-1:0] rem;
  logic [pxc_pkg::NUM_CH-1:0][pxc_pkg::CH_W-1:0] quo_q;
  logic [pxc_pkg::NUM_CH-1:0][pxc_pkg::REM_W-1:0] rem_q;
  pxc_pkg::pixel_t                               src_q;
  pxc_pkg::ctl_t                                 ctl_q;
  pxc_pkg::pixel_t                               blend_pix;

  assign in_ready = !est_valid || est_ready;
  assign est_ready = !out_valid || out_ready;

  // Estimate the quotient with a shift by 16; the remainder then stays
  // below four times the divisor.
  always_comb begin
    for (int ch = 0; ch < pxc_pkg::NUM_CH; ch++) begin
      quo[ch] = prod[ch][pxc_pkg::PROD_W-1 -: pxc_pkg::CH_W];
      rem[ch] = {2'b00, prod[ch][pxc_pkg::WGT_W-1:0]}
              + {1'b0, quo[ch], 9'd0} - {10'd0, quo[ch]};
    end
  end

  always_comb begin
    for (int ch = 0; ch < pxc_pkg::NUM_CH; ch++) begin
      blend_pix[ch*pxc_pkg::CH_W +: pxc_pkg::CH_W] = quo_q[ch]
        + pxc_pkg::CH_W'(rem_q[ch] >= pxc_pkg::DEN_X1)
        + pxc_pkg::CH_W'(rem_q[ch] >= pxc_pkg::DEN_X2)
        + pxc_pkg::CH_W'(rem_q[ch] >= pxc_pkg::DEN_X3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      est_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        est_valid <= in_valid;
      end
      if (est_ready) begin
        out_valid <= est_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      quo_q <= quo;
      rem_q <= rem;
      src_q <= src_pixel;
      ctl_q <= ctl;
    end
    if (est_ready && est_valid) begin
      out_pixel <= ctl_q.blend ? blend_pix : src_q;
      write_enable <= ctl_q.we;
    end
  end

endmodule

// ===== rtl/pixel_compositor_core.sv =====
// Top level of the pixel compositor: configuration registers and pipeline.
//
//   Channel  Handshake               Payload
//   input    in_valid / in_ready     src_pixel, dst_pixel
//   output   out_valid / out_ready   out_pixel, write_enable
//   config   cfg_we                  cfg_index, cfg_data
//
// Four register stages: decode and weight, channel products, quotient
// estimate, correction into the output register. One pixel per clock while
// out_ready is high. Each stage takes a new transfer when it is empty or
// its successor advances, so bubbles close up and a stall loses nothing.
// Reset clears the valid bits and loads the register reset values.
`timescale 1ns / 1ps
`include "pixel_compositor_core_defines.svh"

module pixel_compositor_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [31:0]               src_pixel,
  input  logic [31:0]               dst_pixel,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [31:0]               out_pixel,
  output logic                      write_enable,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [31:0]               cfg_data
);

  logic [2:0]                 blend_mode;
  pxc_pkg::pixel_t            key_color;
  logic [pxc_pkg::CH_W-1:0]   alpha_level;

  logic                       f_valid;
  logic                       f_ready;
  pxc_pkg::pixel_t            f_src;
  pxc_pkg::pixel_t            f_dst;
  logic [pxc_pkg::WGT_W-1:0]  f_wgt;
  pxc_pkg::ctl_t              f_ctl;

  logic                       m_valid;
  logic                       m_ready;
  pxc_pkg::pixel_t            m_src;
  pxc_pkg::prod_t             m_prod;
  pxc_pkg::ctl_t              m_ctl;

  logic                       key_mode;
  logic                       test_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode <= pxc_pkg::BLEND_MODE_RESET;
      key_color <= pxc_pkg::KEY_COLOR_RESET;
      alpha_level <= pxc_pkg::ALPHA_LEVEL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pxc_pkg::REG_BLEND_MODE:  blend_mode <= cfg_data[2:0];
        pxc_pkg::REG_KEY_COLOR:   key_color <= cfg_data;
        pxc_pkg::REG_ALPHA_LEVEL: alpha_level <= cfg_data[pxc_pkg::CH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pxc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .src_pixel   (src_pixel),
    .dst_pixel   (dst_pixel),
    .blend_mode  (blend_mode),
    .key_color   (key_color),
    .alpha_level (alpha_level),
    .out_valid   (f_valid),
    .out_ready   (f_ready),
    .src_q       (f_src),
    .dst_q       (f_dst),
    .wgt_q       (f_wgt),
    .ctl_q       (f_ctl)
  );

  pxc_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .src_pixel (f_src),
    .dst_pixel (f_dst),
    .wgt       (f_wgt),
    .ctl       (f_ctl),
    .out_valid (m_valid),
    .out_ready (m_ready),
    .src_q     (m_src),
    .prod_q    (m_prod),
    .ctl_q     (m_ctl)
  );

  pxc_div u_div (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (m_valid),
    .in_ready     (m_ready),
    .src_pixel    (m_src),
    .prod         (m_prod),
    .ctl          (m_ctl),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pixel    (out_pixel),
    .write_enable (write_enable)
  );

  assign key_mode = (blend_mode == pxc_pkg::MODE_KEY);
  assign test_mode = (blend_mode == pxc_pkg::MODE_TEST);

  `PXC_ASSERT_NOW(a_copy_writes, out_valid && blend_mode == pxc_pkg::MODE_COPY, write_enable)
  `PXC_ASSERT_NOW(a_skip_only_key_test, out_valid && !write_enable, key_mode || test_mode)
  `PXC_ASSERT_NOW(a_key_never_written, out_valid && write_enable && key_mode, out_pixel != key_color)

endmodule

// ===== bench/tb_pixel_compositor_core.sv =====
// Self-checking testbench of the pixel compositor core: directed table, then random phases.
`timescale 1ns / 1ps

module tb_pixel_compositor_core;

  localparam logic [2:0] MODE_SPARE5 = 3'd5;
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASES = 26;
  localparam int PHASE_ITEMS = 50;

  typedef struct packed {
    pxc_pkg::pixel_t pix;
    logic we;
  } result_t;

  typedef struct packed {
    logic cfg;
    logic [31:0] mode_w;
    logic [31:0] key_w;
    logic [31:0] level_w;
    logic spare;
    pxc_pkg::pixel_t src;
    pxc_pkg::pixel_t dst;
    logic typed;
    pxc_pkg::pixel_t xpix;
    logic xwe;
  } dir_row_t;

  localparam dir_row_t DIRECTED [24] = '{
    '{1'b0, 32'd0, 32'd0, 32'd0, 1'b0, 32'hDEADBEEF, 32'h00000000, 1'b1, 32'hDEADBEEF, 1'b1},
    '{1'b0, 32'd0, 32'd0, 32'd0, 1'b0, 32'h00000000, 32'hFFFFFFFF, 1'b1, 32'h00000000, 1'b1},
    '{1'b1, 32'(pxc_pkg::MODE_KEY), 32'h11223344, 32'd255, 1'b1,
      32'h11223344, 32'h00000000, 1'b1, 32'h11223344, 1'b0},
    '{1'b0, 32'd0, 32'd0, 32'd0, 1'b0, 32'h11223345, 32'h00000000, 1'b1, 32'h11223345, 1'b1},
    '{1'b1, 32'(pxc_pkg::MODE_KEY), 32'hFFFFFFFF, 32'd255, 1'b0,
      32'hFFFFFFFF, 32'h00000000, 1'b1, 32'hFFFFFFFF, 1'b0},
    '{1'b1, 32'(pxc_pkg::MODE_KEY), 32'h00000000, 32'd255, 1'b0,
      32'h00000000, 32'hFFFFFFFF, 1'b1, 32'h00000000, 1'b0},
    '{1'b1, {29'h1, pxc_pkg::MODE_KEY}, 32'hA5A5A5A5, 32'd0, 1'b1,
      32'hA5A5A5A5, 32'h00000000, 1'b1, 32'hA5A5A5A5, 1'b0},
    '{1'b1, 32'(pxc_pkg::MODE_TEST), 32'd0, 32'h80, 1'b0,
      32'h80FFFFFF, 32'h00000000, 1'b1, 32'h80FFFFFF, 1'b0},
    '{1'b0, 32'd0, 32'd0, 32'd0, 1'b0, 32'h81000000, 32'h00000000, 1'b1, 32'h81000000, 1'b1},
    '{1'b1, 32'(pxc_pkg::MODE_TEST), 32'd0, 32'h00, 1'b0,
      32'h00FFFFFF, 32'h00000000, 1'b1, 32'h00FFFFFF, 1'b0},
    '{1'b0, 32'd0, 32'd0, 32'd0, 1'b0, 32'h01000000, 32'h00000000, 1'b1, 32'h01000000, 1'b1},
    '{1'b1, 32'(pxc_pkg::MODE_TEST), 32'd0, 32'hFF, 1'b0,
      32'hFFFFFFFF, 32'h00000000, 1'b1, 32'hFFFFFFFF, 1'b0},
    '{1'b1, 32'(pxc_pkg::MODE_PIXBLEND), 32'd0, 32'hFF, 1'b1,
      32'hFF123456, 32'h00ABCDEF, 1'b1, 32'hFF123456, 1'b1},
    '{1'b0, 32'd0, 32'd0, 32'd0, 1'b0, 32'h00123456, 32'h89ABCDEF, 1'b1, 32'h89ABCDEF, 1'b1},
    '{1'b1, 32'(pxc_pkg::MODE_PIXBLEND), 32'd0, 32'h00, 1'b0,
      32'hFFFFFFFF, 32'h12345678, 1'b1, 32'h12345678, 1'b1},
    '{1'b1, 32'(pxc_pkg::MODE_PIXBLEND), 32'd0, 32'h80, 1'b0,
      32'h80FF00FF, 32'h00FF0000, 1'b0, 32'h0, 1'b0},
    '{1'b1, 32'(pxc_pkg::MODE_CONSTBLEND), 32'd0, 32'hFF, 1'b0,
      32'h00000000, 32'hFFFFFFFF, 1'b1, 32'h00000000, 1'b1},
    '{1'b1, 32'(pxc_pkg::MODE_CONSTBLEND), 32'd0, 32'h00, 1'b0,
      32'hFFFFFFFF, 32'h00000000, 1'b1, 32'h00000000, 1'b1},
    '{1'b1, 32'(pxc_pkg::MODE_CONSTBLEND), 32'd0, 32'h64, 1'b1,
      32'hFFFFFFFF, 32'h00000000, 1'b0, 32'h0, 1'b0},
    '{1'b1, 32'(pxc_pkg::MODE_CONSTBLEND), 32'd0, 32'hFFFFFF00, 1'b0,
      32'h7F7F7F7F, 32'h01020304, 1'b1, 32'h01020304, 1'b1},
    '{1'b1, {29'h1FFFFFFF, MODE_SPARE5}, 32'd0, 32'hFF, 1'b0,
      32'h0F1E2D3C, 32'h00000000, 1'b1, 32'h0F1E2D3C, 1'b1},
    '{1'b1, 32'(MODE_SPARE6), 32'd0, 32'hFF, 1'b0,
      32'h00FF00FF, 32'hFF00FF00, 1'b1, 32'h00FF00FF, 1'b1},
    '{1'b1, {29'h1FFFFFFF, MODE_SPARE7}, 32'd0, 32'hFF, 1'b0,
      32'hFFFFFFFF, 32'h00000000, 1'b1, 32'hFFFFFFFF, 1'b1},
    '{1'b1, 32'(pxc_pkg::MODE_CONSTBLEND), 32'd0, 32'h123456C8, 1'b0,
      32'hC0C0C0C0, 32'h40404040, 1'b0, 32'h0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [31:0] src_pixel;
  logic [31:0] dst_pixel;
  logic out_valid;
  logic out_ready;
  logic [31:0] out_pixel;
  logic write_enable;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  logic [2:0] cur_mode = pxc_pkg::BLEND_MODE_RESET;
  pxc_pkg::pixel_t cur_key = pxc_pkg::KEY_COLOR_RESET;
  logic [7:0] cur_level = pxc_pkg::ALPHA_LEVEL_RESET;

  result_t expected_writes [$];
  int mismatches = 0;
  int cycles = 0;
  bit in_idle = 1'b0;
  bit out_idle = 1'b0;

  pixel_compositor_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .src_pixel(src_pixel),
    .dst_pixel(dst_pixel),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_pixel(out_pixel),
    .write_enable(write_enable),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic result_t composite(pxc_pkg::pixel_t s, pxc_pkg::pixel_t d);
    result_t r;
    int unsigned weight;
    int unsigned full;
    int unsigned sc;
    int unsigned dc;
    r.pix = s;
    r.we = 1'b1;
    case (cur_mode)
      pxc_pkg::MODE_KEY: r.we = (s != cur_key);
      pxc_pkg::MODE_TEST: r.we = (s[31:24] > cur_level);
      pxc_pkg::MODE_PIXBLEND, pxc_pkg::MODE_CONSTBLEND: begin
        if (cur_mode == pxc_pkg::MODE_PIXBLEND) begin
          weight = 32'(s[31:24]) * 32'(cur_level);
          full = 65025;
        end else begin
          weight = 32'(cur_level);
          full = 255;
        end
        for (int ch = 0; ch < 4; ch++) begin
          sc = 32'(s[8*ch +: 8]);
          dc = 32'(d[8*ch +: 8]);
          r.pix[8*ch +: 8] = 8'((dc * (full - weight) + sc * weight) / full);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic pxc_pkg::pixel_t rand_pixel();
    pxc_pkg::pixel_t p;
    case ($urandom_range(0, 7))
      0: p = '0;
      1: p = '1;
      2: begin
        for (int ch = 0; ch < 4; ch++) p[8*ch +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      default: p = $urandom();
    endcase
    return p;
  endfunction

  // The task leaves in_valid high on return; back-to-back calls keep it high unless in_idle inserts a gap.
  task automatic send_pixel(pxc_pkg::pixel_t s, pxc_pkg::pixel_t d, logic typed,
                            pxc_pkg::pixel_t xp, logic xwe);
    if (in_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    if (typed) expected_writes.push_back('{pix: xp, we: xwe});
    else expected_writes.push_back(composite(s, d));
    in_valid <= 1'b1;
    src_pixel <= s;
    dst_pixel <= d;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      pxc_pkg::REG_BLEND_MODE: cur_mode = data[2:0];
      pxc_pkg::REG_KEY_COLOR: cur_key = data;
      pxc_pkg::REG_ALPHA_LEVEL: cur_level = data[7:0];
      default: ;
    endcase
  endtask

  initial begin
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_idle && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_writes
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_writes.size() == 0) begin
        $display("%0t: unexpected transfer, actual out_pixel %h write_enable %b",
                 $time, out_pixel, write_enable);
        mismatches++;
      end else begin
        want = expected_writes.pop_front();
        if (out_pixel !== want.pix) begin
          $display("%0t: out_pixel expected %h actual %h", $time, want.pix, out_pixel);
          mismatches++;
        end
        if (write_enable !== want.we) begin
          $display("%0t: write_enable expected %b actual %b", $time, want.we, write_enable);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    dir_row_t row;
    pxc_pkg::pixel_t s;
    pxc_pkg::pixel_t d;
    logic [31:0] data;
    logic [2:0] m;
    rst <= 1'b1;
    in_valid <= 1'b0;
    src_pixel <= '0;
    dst_pixel <= '0;
    cfg_we <= 1'b0;
    cfg_index <= pxc_pkg::REG_BLEND_MODE;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    in_idle = 1'b1;
    out_idle = 1'b1;

    for (int i = 0; i < 24; i++) begin
      row = DIRECTED[i];
      if (row.cfg) begin
        drain();
        write_reg(pxc_pkg::REG_BLEND_MODE, row.mode_w);
        write_reg(pxc_pkg::REG_KEY_COLOR, row.key_w);
        write_reg(pxc_pkg::REG_ALPHA_LEVEL, row.level_w);
        if (row.spare) write_reg(REG_SPARE, 32'hFFFFFFFF);
        cfg_we <= 1'b0;
      end
      send_pixel(row.src, row.dst, row.typed, row.xpix, row.xwe);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      in_idle = (ph < PHASES - 3) && ($urandom_range(0, 3) != 0);
      out_idle = (ph < PHASES - 3) && ($urandom_range(0, 3) != 0);
      m = 3'($urandom_range(0, 7));
      if (m > pxc_pkg::MODE_CONSTBLEND && $urandom_range(0, 1)) m = 3'($urandom_range(0, 4));
      data = $urandom();
      data[2:0] = m;
      if ($urandom_range(0, 1)) write_reg(REG_SPARE, $urandom());
      write_reg(pxc_pkg::REG_BLEND_MODE, data);
      write_reg(pxc_pkg::REG_KEY_COLOR, rand_pixel());
      data = $urandom();
      case ($urandom_range(0, 3))
        0: data[7:0] = 8'h00;
        1: data[7:0] = 8'hFF;
        default: ;
      endcase
      write_reg(pxc_pkg::REG_ALPHA_LEVEL, data);
      cfg_we <= 1'b0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        s = rand_pixel();
        d = rand_pixel();
        case (cur_mode)
          pxc_pkg::MODE_KEY: if ($urandom_range(0, 2) == 0) s = cur_key;
          pxc_pkg::MODE_TEST: begin
            if ($urandom_range(0, 1)) s[31:24] = cur_level + 8'($urandom_range(0, 2)) - 8'd1;
          end
          default: ;
        endcase
        send_pixel(s, d, 1'b0, '0, 1'b0);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pxc_pkg.sv
rtl/pxc_front.sv
rtl/pxc_mix.sv
rtl/pxc_div.sv
rtl/pixel_compositor_core.sv
bench/tb_pixel_compositor_core.sv
